// ----- design/rqs_pkg.sv -----
// Shared types, widths and codes for the record queue with key sort.
package rqs_pkg;

   // Queue geometry
   localparam int DEPTH   = 16;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int MAX_OUT = 16;
   localparam int DISP_N  = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int ID_W     = 16;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [KEY_W-1:0] KEY_MIN_RESET = 16'd0;
   localparam logic [KEY_W-1:0] KEY_MAX_RESET = 16'd1000;
   localparam logic REG_KEY_MIN = 1'b0;
   localparam logic REG_KEY_MAX = 1'b1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SORT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DISP = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // One stored record
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Accepted key range
   typedef struct packed {
      logic [KEY_W-1:0] key_min;
      logic [KEY_W-1:0] key_max;
   } cfg_type;

endpackage

// ----- design/rqs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write when enabled, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rqs_csr.sv -----
// Key range registers behind the APB-style register port.
module rqs_csr import rqs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [KEY_W-1:0] key_min_ff;
   logic [KEY_W-1:0] key_max_ff;
   logic             wr_hit;
   logic             reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_hit  = psel & penable & pwrite;

   // Write the selected register on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         key_min_ff <= KEY_MIN_RESET;
         key_max_ff <= KEY_MAX_RESET;
      end else if (wr_hit) begin
         if (reg_sel == REG_KEY_MIN) begin
            key_min_ff <= pwdata[KEY_W-1:0];
         end else begin
            key_max_ff <= pwdata[KEY_W-1:0];
         end
      end
   end

   // Return the selected register
   always_comb begin
      prdata = '0;
      if (reg_sel == REG_KEY_MIN) begin
         prdata[KEY_W-1:0] = key_min_ff;
      end else begin
         prdata[KEY_W-1:0] = key_max_ff;
      end
   end

   assign cfg.key_min = key_min_ff;
   assign cfg.key_max = key_max_ff;

endmodule

// ----- design/rqs_ctrl.sv -----
// Command sequencer: circular queue over one RAM, with one signed key comparator for the sort.
module rqs_ctrl import rqs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [ID_W-1:0]     req_record_id,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [KEY_W-1:0]    rsp_out_key,
   output logic [FILL_W-1:0]   rsp_fill,
   output logic                rsp_last
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DEQ_RD    = 4'd1;
   localparam logic [3:0] S_DEQ_OUT   = 4'd2;
   localparam logic [3:0] S_DISP_RD   = 4'd3;
   localparam logic [3:0] S_DISP_OUT  = 4'd4;
   localparam logic [3:0] S_SORT_RD_I = 4'd5;
   localparam logic [3:0] S_SORT_LD_I = 4'd6;
   localparam logic [3:0] S_SORT_CMP  = 4'd7;
   localparam logic [3:0] S_SORT_RD_J = 4'd8;
   localparam logic [3:0] S_SORT_PUT  = 4'd9;

   logic [3:0]          state_ff,  state_in;
   logic [PTR_W-1:0]    head_ff,   head_in;
   logic [CNT_W-1:0]    count_ff,  count_in;
   logic [PTR_W-1:0]    i_ff,      i_in;
   logic [PTR_W-1:0]    j_ff,      j_in;
   entry_type           hold_ff,   hold_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff,     rsp_id_in;
   logic [KEY_W-1:0]    rsp_key_ff,    rsp_key_in;
   logic [FILL_W-1:0]   rsp_fill_ff,   rsp_fill_in;
   logic                rsp_last_ff,   rsp_last_in;

   logic                wr_en;
   logic [PTR_W-1:0]    wr_addr;
   entry_type           wr_data;
   logic [PTR_W-1:0]    rd_addr;
   entry_type           rd_data;
   logic [ENTRY_W-1:0]  rd_word;

   logic [KEY_W-1:0]    cmp_a;
   logic [KEY_W-1:0]    cmp_b;
   logic                cmp_lt;
   logic                key_low;
   logic                key_high;
   logic [CNT_W-1:0]    disp_n;
   logic [CNT_W-1:0]    i_next;
   logic                sort_adv;

   // Map a queue position to a RAM slot
   function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] ofs);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= (PTR_W+1)'(DEPTH)) begin
         sum = sum - (PTR_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   rqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_data = entry_type'(rd_word);

   // Signed key comparator: stored key against held key while sorting
   assign cmp_a  = rd_data.key;
   assign cmp_b  = hold_ff.key;
   assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

   // Range check for enqueue
   assign key_low  = $signed(req_key) < $signed(cfg.key_min);
   assign key_high = $signed(req_key) > $signed(cfg.key_max);

   assign disp_n = (count_ff > CNT_W'(DISP_N)) ? CNT_W'(DISP_N) : count_ff;
   assign i_next = CNT_W'(i_ff) + CNT_W'(1);
   assign busy   = (state_ff != S_IDLE);

   // Sequence the commands
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_addr(head_ff, j_ff);
      wr_data       = hold_ff;
      rd_addr       = head_ff;
      sort_adv      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  CMD_ENQ: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = '0;
                     rsp_key_in   = '0;
                     rsp_last_in  = 1'b1;
                     if (key_low || key_high) begin
                        rsp_status_in = ST_RANGE;
                        rsp_fill_in   = FILL_W'(count_ff);
                     end else if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                        rsp_fill_in   = FILL_W'(count_ff);
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = slot_addr(head_ff, PTR_W'(count_ff));
                        wr_data.id    = req_record_id;
                        wr_data.key   = req_key;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = ST_OK;
                        rsp_fill_in   = FILL_W'(count_ff + CNT_W'(1));
                     end
                  end
                  CMD_DEQ: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_id_in     = '0;
                        rsp_key_in    = '0;
                        rsp_fill_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in = S_DEQ_RD;
                     end
                  end
                  CMD_SORT: begin
                     if (count_ff <= CNT_W'(1)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_id_in     = '0;
                        rsp_key_in    = '0;
                        rsp_fill_in   = FILL_W'(count_ff);
                        rsp_last_in   = 1'b1;
                     end else begin
                        i_in     = PTR_W'(1);
                        state_in = S_SORT_RD_I;
                     end
                  end
                  CMD_DISP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_id_in     = '0;
                        rsp_key_in    = '0;
                        rsp_fill_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        i_in     = '0;
                        state_in = S_DISP_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Dequeue: read the front slot, then drop it
         S_DEQ_RD: begin
            rd_addr  = head_ff;
            state_in = S_DEQ_OUT;
         end
         S_DEQ_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_id_in     = rd_data.id;
            rsp_key_in    = rd_data.key;
            rsp_fill_in   = FILL_W'(count_ff - CNT_W'(1));
            rsp_last_in   = 1'b1;
            head_in       = slot_addr(head_ff, PTR_W'(1));
            count_in      = count_ff - CNT_W'(1);
            state_in      = S_IDLE;
         end

         // Display: one read and one item per entry
         S_DISP_RD: begin
            rd_addr  = slot_addr(head_ff, i_ff);
            state_in = S_DISP_OUT;
         end
         S_DISP_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_id_in     = rd_data.id;
            rsp_key_in    = rd_data.key;
            rsp_fill_in   = FILL_W'(count_ff);
            rsp_last_in   = (i_next == disp_n);
            if (i_next == disp_n) begin
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff + PTR_W'(1);
               state_in = S_DISP_RD;
            end
         end

         // Sort: pick up entry i, shift entries with smaller keys right until it fits
         S_SORT_RD_I: begin
            rd_addr  = slot_addr(head_ff, i_ff);
            state_in = S_SORT_LD_I;
         end
         S_SORT_LD_I: begin
            hold_in  = rd_data;
            j_in     = i_ff;
            rd_addr  = slot_addr(head_ff, i_ff - PTR_W'(1));
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = slot_addr(head_ff, j_ff);
            if (cmp_lt) begin
               wr_data = rd_data;
               j_in    = j_ff - PTR_W'(1);
               if (j_ff == PTR_W'(1)) begin
                  state_in = S_SORT_PUT;
               end else begin
                  state_in = S_SORT_RD_J;
               end
            end else begin
               wr_data  = hold_ff;
               sort_adv = 1'b1;
            end
         end
         S_SORT_RD_J: begin
            rd_addr  = slot_addr(head_ff, j_ff - PTR_W'(1));
            state_in = S_SORT_CMP;
         end
         S_SORT_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = slot_addr(head_ff, j_ff);
            wr_data  = hold_ff;
            sort_adv = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Advance to the next entry or finish the sort
      if (sort_adv) begin
         if (i_next < count_ff) begin
            i_in     = i_ff + PTR_W'(1);
            state_in = S_SORT_RD_I;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_id_in     = '0;
            rsp_key_in    = '0;
            rsp_fill_in   = FILL_W'(count_ff);
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_out_id  = rsp_id_ff;
   assign rsp_out_key = rsp_key_ff;
   assign rsp_fill    = rsp_fill_ff;
   assign rsp_last    = rsp_last_ff;

   // Fill never exceeds the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   // A display item that is not the last is followed by another read
   a_disp_continue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> state_ff == S_DISP_RD)
      else $error("display stopped before its last item");

   // Error items carry no record
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_id_ff == '0 && rsp_key_ff == '0)
      else $error("error item carries record data");

   // A sequencer run ends with a last item
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid_ff && rsp_last_ff)
      else $error("command finished without a last item");

endmodule

// ----- design/record_queue_with_key_sort.sv -----
// Top level: record queue with stable descending key sort.
// Enqueue: result in the cycle after start, busy stays low, next item may follow at once.
// Dequeue: result after DEQ_RD and DEQ_OUT; display: DISP_RD and DISP_OUT per entry,
//   up to 16 items. Sort: insertion sort over n entries; each entry takes SORT_RD_I,
//   SORT_LD_I and SORT_CMP, each shift adds SORT_CMP and SORT_RD_J, an entry at the front
//   is written in SORT_PUT; the single RAM read port with registered data sets it.
// Reset empties the queue at once (no clearing pass), key_min 0, key_max 1000;
//   every result is strobed for one cycle and cannot be stalled.
module record_queue_with_key_sort import rqs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [ID_W-1:0]       req_record_id,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ID_W-1:0]       rsp_out_id,
   output logic signed [KEY_W-1:0] rsp_out_key,
   output logic [FILL_W-1:0]     rsp_fill,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type          cfg;
   logic [KEY_W-1:0] out_key;

   rqs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rqs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_record_id (req_record_id),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_id    (rsp_out_id),
      .rsp_out_key   (out_key),
      .rsp_fill      (rsp_fill),
      .rsp_last      (rsp_last)
   );

   assign rsp_out_key = $signed(out_key);

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the record queue with key sort: directed table, random phases, self-check.
module tb_top import rqs_pkg::*; ();

   localparam int PHASES     = 6;
   localparam int PHASE_ITEMS = 24;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_WAIT = 40;

   // One result item as the block should produce it
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [ID_W-1:0]         id;
      logic signed [KEY_W-1:0] key;
      logic [FILL_W-1:0]       fill;
      logic                    last;
   } result_type;

   // One row of the directed table; typed rows carry their own single result
   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [ID_W-1:0]         id;
      logic signed [KEY_W-1:0] key;
      logic                    typed;
      result_type              res;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CMD_W-1:0]        req_cmd = CMD_ENQ;
   logic [ID_W-1:0]         req_record_id = '0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [ID_W-1:0]         rsp_out_id;
   logic signed [KEY_W-1:0] rsp_out_key;
   logic [FILL_W-1:0]       rsp_fill;
   logic                    rsp_last;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [CSR_DATA_W-1:0]   pwdata = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   // Mirror of the queue contents and the accepted key range
   logic [ID_W-1:0]         queue_ids [DEPTH];
   logic signed [KEY_W-1:0] queue_keys [DEPTH];
   int                      queue_len = 0;
   logic signed [KEY_W-1:0] key_lo = KEY_MIN_RESET;
   logic signed [KEY_W-1:0] key_hi = KEY_MAX_RESET;

   result_type   step_results [$];
   result_type   due_results [$];
   stim_row_type directed_rows [$];
   int           mismatches = 0;
   int           idle_cycles = 0;

   record_queue_with_key_sort DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_record_id(req_record_id), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_out_id(rsp_out_id),
      .rsp_out_key(rsp_out_key), .rsp_fill(rsp_fill), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic result_type make_result(input logic [STATUS_W-1:0] st,
                                              input logic [ID_W-1:0] id,
                                              input logic signed [KEY_W-1:0] k,
                                              input int fill, input logic last);
      result_type r;
      r.status = st;
      r.id     = id;
      r.key    = k;
      r.fill   = FILL_W'(fill);
      r.last   = last;
      return r;
   endfunction

   // Stable insertion sort of the mirror, highest key first
   function automatic void sort_queue_desc();
      int j;
      logic [ID_W-1:0] hold_id;
      logic signed [KEY_W-1:0] hold_key;
      for (int i = 1; i < queue_len; i++) begin
         hold_id  = queue_ids[i];
         hold_key = queue_keys[i];
         j = i;
         while (j > 0 && queue_keys[j-1] < hold_key) begin
            queue_ids[j]  = queue_ids[j-1];
            queue_keys[j] = queue_keys[j-1];
            j--;
         end
         queue_ids[j]  = hold_id;
         queue_keys[j] = hold_key;
      end
   endfunction

   // Update the mirror for one accepted item and list the results it causes
   function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                         input logic [ID_W-1:0] id,
                                         input logic signed [KEY_W-1:0] k);
      int n;
      step_results.delete();
      case (cmd)
         CMD_ENQ: begin
            if (k < key_lo || k > key_hi)
               step_results.push_back(make_result(ST_RANGE, '0, '0, queue_len, 1'b1));
            else if (queue_len >= DEPTH)
               step_results.push_back(make_result(ST_FULL, '0, '0, queue_len, 1'b1));
            else begin
               queue_ids[queue_len]  = id;
               queue_keys[queue_len] = k;
               queue_len++;
               step_results.push_back(make_result(ST_OK, '0, '0, queue_len, 1'b1));
            end
         end
         CMD_DEQ: begin
            if (queue_len == 0)
               step_results.push_back(make_result(ST_EMPTY, '0, '0, 0, 1'b1));
            else begin
               step_results.push_back(make_result(ST_OK, queue_ids[0], queue_keys[0],
                                                  queue_len - 1, 1'b1));
               for (int i = 1; i < queue_len; i++) begin
                  queue_ids[i-1]  = queue_ids[i];
                  queue_keys[i-1] = queue_keys[i];
               end
               queue_len--;
            end
         end
         CMD_SORT: begin
            sort_queue_desc();
            step_results.push_back(make_result(ST_OK, '0, '0, queue_len, 1'b1));
         end
         default: begin
            if (queue_len == 0)
               step_results.push_back(make_result(ST_EMPTY, '0, '0, 0, 1'b1));
            else begin
               n = (queue_len < DISP_N) ? queue_len : DISP_N;
               for (int i = 0; i < n; i++)
                  step_results.push_back(make_result(ST_OK, queue_ids[i], queue_keys[i],
                                                     queue_len, i == n - 1));
            end
         end
      endcase
   endfunction

   function automatic stim_row_type make_row(input logic [CMD_W-1:0] cmd,
                                             input logic [ID_W-1:0] id,
                                             input logic signed [KEY_W-1:0] k,
                                             input logic typed,
                                             input logic [STATUS_W-1:0] st, input int fill);
      stim_row_type r;
      r.cmd   = cmd;
      r.id    = id;
      r.key   = k;
      r.typed = typed;
      r.res   = make_result(st, '0, '0, fill, 1'b1);
      return r;
   endfunction

   // Present one item after a gap, hold it until accepted, then log what is due
   task automatic issue_item(input stim_row_type row, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_cmd       <= row.cmd;
      req_record_id <= row.id;
      req_key       <= row.key;
      do @(posedge clock); while (busy);
      apply_command(row.cmd, row.id, row.key);
      if (row.typed)
         due_results.push_back(row.res);
      else
         foreach (step_results[i]) due_results.push_back(step_results[i]);
   endtask

   // Write one key limit while the block is idle, then read it back
   task automatic set_key_limit(input logic idx, input logic signed [KEY_W-1:0] val);
      while (due_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= {{(CSR_DATA_W-KEY_W){val[KEY_W-1]}}, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_KEY_MIN) key_lo = val;
      else key_hi = val;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[KEY_W-1:0] !== val)
         report_mismatch("key limit readback", prdata[KEY_W-1:0], val);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Draw an enqueue key: mostly in range with ties, some at and past the edges
   function automatic logic signed [KEY_W-1:0] pick_key();
      int lo, hi, v, span;
      lo = key_lo;
      hi = key_hi;
      span = hi - lo;
      case ($urandom_range(0, 7))
         0: v = int'($urandom_range(0, 65535)) - 32768;
         1: v = lo - 1;
         2: v = hi + 1;
         3: v = lo;
         4: v = hi;
         5: v = (span >= 0) ? lo + int'($urandom_range(0, (span > 3) ? 3 : span))
                            : int'($urandom_range(0, 65535)) - 32768;
         default: v = (span >= 0) ? lo + int'($urandom_range(0, span))
                                  : int'($urandom_range(0, 65535)) - 32768;
      endcase
      return v[KEY_W-1:0];
   endfunction

   // Check every strobed result against the oldest one due
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0)
            report_mismatch("result with nothing due", 1, 0);
         else begin
            want = due_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_out_id !== want.id)
               report_mismatch("out_id", rsp_out_id, want.id);
            if (rsp_out_key !== want.key)
               report_mismatch("out_key", rsp_out_key, want.key);
            if (rsp_fill !== want.fill)
               report_mismatch("fill", rsp_fill, want.fill);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   initial begin
      logic signed [KEY_W-1:0] phase_lo [PHASES];
      logic signed [KEY_W-1:0] phase_hi [PHASES];
      int        phase_enq [PHASES];
      logic [ID_W-1:0] fill_ids [16];
      logic signed [KEY_W-1:0] fill_keys [16];
      stim_row_type row;
      int        pick, rest;
      bit        no_gaps;

      fill_ids  = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hA5A5,
                    16'h5A5A, 16'h1234, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
                    16'h3C3C, 16'hC3C3, 16'h0002, 16'h4000};
      fill_keys = '{16'sd0, 16'sd1000, 16'sd500, 16'sd500, 16'sd1000, 16'sd1, 16'sd999,
                    16'sd250, 16'sd0, 16'sd750, 16'sd500, 16'sd2, 16'sd998, 16'sd100,
                    16'sd1000, 16'sd0};

      // Directed table: empty queue, range edges, fill to full, sort and display
      directed_rows.push_back(make_row(CMD_DISP, '0, '0, 1'b1, ST_EMPTY, 0));
      directed_rows.push_back(make_row(CMD_DEQ, '0, '0, 1'b1, ST_EMPTY, 0));
      directed_rows.push_back(make_row(CMD_SORT, '0, '0, 1'b1, ST_OK, 0));
      directed_rows.push_back(make_row(CMD_ENQ, 16'hFFFF, -16'sd1, 1'b1, ST_RANGE, 0));
      for (int i = 0; i < 16; i++)
         directed_rows.push_back(make_row(CMD_ENQ, fill_ids[i], fill_keys[i], 1'b1,
                                          ST_OK, i + 1));
      directed_rows.push_back(make_row(CMD_ENQ, 16'h9999, 16'sd500, 1'b1, ST_FULL, 16));
      directed_rows.push_back(make_row(CMD_ENQ, 16'h6666, 16'sd1001, 1'b1, ST_RANGE, 16));
      directed_rows.push_back(make_row(CMD_DISP, '0, '0, 1'b0, ST_OK, 0));
      directed_rows.push_back(make_row(CMD_SORT, '0, '0, 1'b1, ST_OK, 16));
      directed_rows.push_back(make_row(CMD_DISP, '0, '0, 1'b0, ST_OK, 0));
      directed_rows.push_back(make_row(CMD_DEQ, '0, '0, 1'b0, ST_OK, 0));

      // Key range per random phase, with the share of enqueues in each
      phase_lo  = '{16'sd0, -16'sd32768, 16'sd100, -16'sd5, 16'sd32767, -16'sd32768};
      phase_hi  = '{16'sd1000, 16'sd32767, -16'sd100, 16'sd5, 16'sd32767, -16'sd32768};
      phase_enq = '{75, 60, 30, 70, 40, 20};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      no_gaps = 1'b0;
      foreach (directed_rows[i]) begin
         if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
         issue_item(directed_rows[i], no_gaps ? 0 : $urandom_range(0, 15));
      end
      start <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         set_key_limit(REG_KEY_MIN, phase_lo[p]);
         set_key_limit(REG_KEY_MAX, phase_hi[p]);
         rest = 100 - phase_enq[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < phase_enq[p]) row.cmd = CMD_ENQ;
            else if (pick < phase_enq[p] + rest / 2) row.cmd = CMD_DEQ;
            else if (pick < phase_enq[p] + (rest * 3) / 4) row.cmd = CMD_SORT;
            else row.cmd = CMD_DISP;
            row.id    = ID_W'($urandom_range(0, 65535));
            row.key   = (row.cmd == CMD_ENQ) ? pick_key()
                                             : KEY_W'($urandom_range(0, 65535));
            row.typed = 1'b0;
            row.res   = '0;
            if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
            issue_item(row, no_gaps ? 0 : $urandom_range(0, 15));
         end
         start <= 1'b0;
      end

      // Drain what is still due, then give stray results a chance to show
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
